### src/nfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the fixed colour table of the nibble frame scaler.
package nfs_pkg;

	// configuration register indexes
	localparam logic REG_SCALE_MODE = 1'b0;
	localparam logic REG_BORDER_ON  = 1'b1;

	// scale_mode codes; the unused code behaves as SCALE_NONE
	localparam logic [2:0] SCALE_NONE = 3'd0;
	localparam logic [2:0] SCALE_50   = 3'd1;
	localparam logic [2:0] SCALE_75   = 3'd2;
	localparam logic [2:0] SCALE_84   = 3'd3;
	localparam logic [2:0] SCALE_112  = 3'd4;
	localparam logic [2:0] SCALE_125  = 3'd5;
	localparam logic [2:0] SCALE_150  = 3'd6;

	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = 2;

	// one item's worth of pixel work, handed from front to back
	typedef struct packed {
		logic [8:0] x;
		logic [7:0] y;
		logic [3:0] lcode;
		logic [3:0] rcode;
		logic       twice;
		logic [2:0] mask;   // bit0 left at x, bit1 right at x+1, bit2 right at x+2
	} job_t;

	function automatic logic [15:0] pal_color(input logic [3:0] code);
		logic [15:0] c;
		case (code)
			4'd0:    c = 16'h0000;
			4'd1:    c = 16'h001B;
			4'd2:    c = 16'hD800;
			4'd3:    c = 16'hD81B;
			4'd4:    c = 16'h06C0;
			4'd5:    c = 16'h06DB;
			4'd6:    c = 16'hDEC0;
			4'd7:    c = 16'hDEDB;
			4'd8:    c = 16'h0000;
			4'd9:    c = 16'h001F;
			4'd10:   c = 16'hF800;
			4'd11:   c = 16'hF81F;
			4'd12:   c = 16'h07E0;
			4'd13:   c = 16'h07FF;
			4'd14:   c = 16'hFFE0;
			4'd15:   c = 16'hFFFF;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

endpackage

### src/nfs_front.sv
`timescale 1ns / 1ps
// Front end: config registers, raster counters and per-item pixel job generation.
module nfs_front #(
	parameter int DISP_WIDTH        = 320,
	parameter int DISP_HEIGHT       = 240,
	parameter int SRC_ROWS          = 256,
	parameter int SRC_BYTES_PER_ROW = 160
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic              take,
	input  logic [7:0]        pixel_pair,
	input  logic              frame_start,
	output logic              job_push,
	output nfs_pkg::job_t     job
);

	localparam int SR_W  = $clog2(SRC_ROWS);
	localparam int SC_W  = $clog2(SRC_BYTES_PER_ROW);
	localparam int OR_W  = $clog2(DISP_HEIGHT + 2);
	localparam int OC_W  = $clog2(DISP_WIDTH + 3);
	localparam int GEO_W = $clog2(2 * SRC_ROWS + 4 * SRC_BYTES_PER_ROW + 64);

	function automatic int row_off(input int z);
		return (z > DISP_HEIGHT) ? ((z - DISP_HEIGHT) >> 1) : 0;
	endfunction

	function automatic int col_off(input int z);
		return (z > DISP_WIDTH) ? ((z - DISP_WIDTH) >> 2) : 0;
	endfunction

	localparam int ZH1 = SRC_ROWS;
	localparam int ZH0 = SRC_ROWS - 64;
	localparam int ZW1 = 2 * SRC_BYTES_PER_ROW;
	localparam int ZW0 = ZW1 - 64;

	localparam int RS1_0 = row_off(ZH1);
	localparam int RS1_1 = row_off(ZH1 * 2 / 3);
	localparam int RS1_2 = row_off(ZH1 * 4 / 5);
	localparam int RS1_3 = row_off(ZH1 * 8 / 9);
	localparam int RS1_4 = row_off(ZH1 * 9 / 8);
	localparam int RS1_5 = row_off(ZH1 * 5 / 4);
	localparam int RS1_6 = row_off(ZH1 * 3 / 2);
	localparam int RS0_0 = 32 + row_off(ZH0);
	localparam int RS0_1 = 32 + row_off(ZH0 * 2 / 3);
	localparam int RS0_2 = 32 + row_off(ZH0 * 4 / 5);
	localparam int RS0_3 = 32 + row_off(ZH0 * 8 / 9);
	localparam int RS0_4 = 32 + row_off(ZH0 * 9 / 8);
	localparam int RS0_5 = 32 + row_off(ZH0 * 5 / 4);
	localparam int RS0_6 = 32 + row_off(ZH0 * 3 / 2);

	localparam int XS1_0 = col_off(ZW1);
	localparam int XS1_1 = col_off(ZW1 * 2 / 3);
	localparam int XS1_2 = col_off(ZW1 * 4 / 5);
	localparam int XS1_3 = col_off(ZW1 * 8 / 9);
	localparam int XS1_4 = col_off(ZW1 * 9 / 8);
	localparam int XS1_5 = col_off(ZW1 * 5 / 4);
	localparam int XS1_6 = col_off(ZW1 * 3 / 2);
	localparam int XS0_0 = 16 + col_off(ZW0);
	localparam int XS0_1 = 16 + col_off(ZW0 * 2 / 3);
	localparam int XS0_2 = 16 + col_off(ZW0 * 4 / 5);
	localparam int XS0_3 = 16 + col_off(ZW0 * 8 / 9);
	localparam int XS0_4 = 16 + col_off(ZW0 * 9 / 8);
	localparam int XS0_5 = 16 + col_off(ZW0 * 5 / 4);
	localparam int XS0_6 = 16 + col_off(ZW0 * 3 / 2);

	logic [2:0]      scale_mode_q;
	logic            border_on_q;
	logic [SR_W-1:0] src_row_q;
	logic [SC_W-1:0] src_col_q;
	logic [2:0]      rows_done_q;
	logic [OR_W-1:0] out_row_q;
	logic [OC_W-1:0] out_col_q;

	logic [GEO_W-1:0] row_start, col_start;
	logic             scaled, dup;
	logic [2:0]       xm, ym;

	logic [SR_W-1:0] sr_e, sr_n;
	logic [SC_W-1:0] sc_e, sc_n;
	logic [2:0]      rd_e, rd_n;
	logic [OR_W-1:0] or_e, or_n;
	logic [OC_W-1:0] oc_e, oc_n;
	logic            rowok, colok, rowhit, skiprow, twice, colhit, lastcol;
	logic            x1ok, x2ok;
	logic [2:0]      mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q <= nfs_pkg::SCALE_NONE;
			border_on_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				nfs_pkg::REG_SCALE_MODE: scale_mode_q <= cfg_data;
				nfs_pkg::REG_BORDER_ON:  border_on_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// scale factors and crop / centring offsets, all constant per setting
	always_comb begin
		scaled = 1'b1;
		dup    = 1'b1;
		xm     = 3'd0;
		ym     = 3'd0;
		case (scale_mode_q)
			nfs_pkg::SCALE_50: begin xm = 3'd0; ym = 3'd1; dup = 1'b0; end
			nfs_pkg::SCALE_75: begin xm = 3'd1; ym = 3'd3; dup = 1'b0; end
			nfs_pkg::SCALE_84: begin xm = 3'd3; ym = 3'd7; dup = 1'b0; end
			nfs_pkg::SCALE_112: begin xm = 3'd3; ym = 3'd7; end
			nfs_pkg::SCALE_125: begin xm = 3'd1; ym = 3'd3; end
			nfs_pkg::SCALE_150: begin xm = 3'd0; ym = 3'd1; end
			default: scaled = 1'b0;
		endcase

		case ({border_on_q, scale_mode_q})
			{1'b1, nfs_pkg::SCALE_50}:  begin row_start = GEO_W'(RS1_1); col_start = GEO_W'(XS1_1); end
			{1'b1, nfs_pkg::SCALE_75}:  begin row_start = GEO_W'(RS1_2); col_start = GEO_W'(XS1_2); end
			{1'b1, nfs_pkg::SCALE_84}:  begin row_start = GEO_W'(RS1_3); col_start = GEO_W'(XS1_3); end
			{1'b1, nfs_pkg::SCALE_112}: begin row_start = GEO_W'(RS1_4); col_start = GEO_W'(XS1_4); end
			{1'b1, nfs_pkg::SCALE_125}: begin row_start = GEO_W'(RS1_5); col_start = GEO_W'(XS1_5); end
			{1'b1, nfs_pkg::SCALE_150}: begin row_start = GEO_W'(RS1_6); col_start = GEO_W'(XS1_6); end
			{1'b0, nfs_pkg::SCALE_50}:  begin row_start = GEO_W'(RS0_1); col_start = GEO_W'(XS0_1); end
			{1'b0, nfs_pkg::SCALE_75}:  begin row_start = GEO_W'(RS0_2); col_start = GEO_W'(XS0_2); end
			{1'b0, nfs_pkg::SCALE_84}:  begin row_start = GEO_W'(RS0_3); col_start = GEO_W'(XS0_3); end
			{1'b0, nfs_pkg::SCALE_112}: begin row_start = GEO_W'(RS0_4); col_start = GEO_W'(XS0_4); end
			{1'b0, nfs_pkg::SCALE_125}: begin row_start = GEO_W'(RS0_5); col_start = GEO_W'(XS0_5); end
			{1'b0, nfs_pkg::SCALE_150}: begin row_start = GEO_W'(RS0_6); col_start = GEO_W'(XS0_6); end
			{1'b0, nfs_pkg::SCALE_NONE}: begin row_start = GEO_W'(RS0_0); col_start = GEO_W'(XS0_0); end
			default: begin
				if (border_on_q) begin
					row_start = GEO_W'(RS1_0);
					col_start = GEO_W'(XS1_0);
				end else begin
					row_start = GEO_W'(RS0_0);
					col_start = GEO_W'(XS0_0);
				end
			end
		endcase
	end

	always_comb begin
		sr_e = frame_start ? '0 : src_row_q;
		sc_e = frame_start ? '0 : src_col_q;
		rd_e = frame_start ? '0 : rows_done_q;
		or_e = frame_start ? '0 : out_row_q;
		oc_e = (sc_e == '0) ? '0 : out_col_q;

		rowok   = (GEO_W'(sr_e) >= row_start) && (or_e < OR_W'(DISP_HEIGHT));
		rowhit  = scaled && ((3'(rd_e + 3'd1) & ym) == 3'd0);
		skiprow = rowhit && !dup;
		twice   = rowhit && dup &&
			((OR_W + 1)'({1'b0, or_e} + 1'b1) < (OR_W + 1)'(DISP_HEIGHT));
		colok   = (GEO_W'(sc_e) >= col_start) && (oc_e < OC_W'(DISP_WIDTH));
		lastcol = (sc_e == SC_W'(SRC_BYTES_PER_ROW - 1));
		colhit  = scaled && ((3'(sc_e + 1'b1) & xm) == 3'd0);
		x1ok    = (OC_W + 1)'({1'b0, oc_e} + 1'b1) < (OC_W + 1)'(DISP_WIDTH);
		x2ok    = (OC_W + 1)'({1'b0, oc_e} + 2'd2) < (OC_W + 1)'(DISP_WIDTH);

		mask = 3'b000;
		if (rowok && colok && !skiprow) begin
			mask[0] = 1'b1;
			// a dropped right pixel is still drawn at the end of a source row
			mask[1] = (!(colhit && !dup) || lastcol) && x1ok;
			mask[2] = colhit && dup && x2ok;
		end

		oc_n = oc_e;
		if (rowok && colok) begin
			if (colhit) oc_n = dup ? OC_W'(oc_e + 2'd3) : OC_W'(oc_e + 1'b1);
			else        oc_n = OC_W'(oc_e + 2'd2);
		end

		sr_n = sr_e;
		sc_n = SC_W'(sc_e + 1'b1);
		rd_n = rd_e;
		or_n = or_e;
		if (lastcol) begin
			sc_n = '0;
			if (rowok) begin
				if (rowhit) or_n = dup ? OR_W'(or_e + 2'd2) : or_e;
				else        or_n = OR_W'(or_e + 1'b1);
				rd_n = 3'(rd_e + 3'd1);
			end
			sr_n = SR_W'(sr_e + 1'b1);
			if (sr_e == SR_W'(SRC_ROWS - 1)) begin
				sr_n = '0;
				rd_n = '0;
				or_n = '0;
				oc_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_row_q   <= '0;
			src_col_q   <= '0;
			rows_done_q <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
		end else if (take) begin
			src_row_q   <= sr_n;
			src_col_q   <= sc_n;
			rows_done_q <= rd_n;
			out_row_q   <= or_n;
			out_col_q   <= oc_n;
		end
	end

	assign job_push  = take && (mask != 3'b000);
	assign job.x     = 9'(oc_e);
	assign job.y     = 8'(or_e);
	assign job.lcode = pixel_pair[7:4];
	assign job.rcode = pixel_pair[3:0];
	assign job.twice = twice;
	assign job.mask  = mask;

endmodule

### src/nfs_jobq.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the pixel emitter.
module nfs_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  nfs_pkg::job_t wdata,
	input  logic          rd,
	output logic          full,
	output logic          head_valid,
	output nfs_pkg::job_t head
);

	nfs_pkg::job_t              mem_q [nfs_pkg::JQ_DEPTH];
	logic [nfs_pkg::JQ_AW-1:0]  wp_q, rp_q;
	logic [nfs_pkg::JQ_AW:0]    cnt_q;

	assign full       = (cnt_q == (nfs_pkg::JQ_AW + 1)'(nfs_pkg::JQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd))
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> head_valid)
		else $error("job queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (nfs_pkg::JQ_AW + 1)'(nfs_pkg::JQ_DEPTH))
		else $error("job queue count out of range");
`endif

endmodule

### src/nfs_back.sv
`timescale 1ns / 1ps
// Back end: expands each job into 1-3 pixels, one per cycle unless the output register is held.
module nfs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  nfs_pkg::job_t head,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output logic [8:0]    disp_x,
	output logic [7:0]    disp_y,
	output logic [15:0]   color,
	output logic          row_twice,
	output logic          last_of_item
);

	logic [2:0]  done_q;
	logic        ov_q;
	logic [2:0]  pend, pbit, rest;
	logic [1:0]  sel;
	logic        load;
	logic [3:0]  code;

	always_comb begin
		pend = head.mask & ~done_q;
		if (pend[0]) begin
			sel  = 2'd0;
			pbit = 3'b001;
		end else if (pend[1]) begin
			sel  = 2'd1;
			pbit = 3'b010;
		end else begin
			sel  = 2'd2;
			pbit = 3'b100;
		end
		rest = pend & ~pbit;
		code = (sel == 2'd0) ? head.lcode : head.rcode;
	end

	// output register is free, or is being drained this cycle
	assign load    = head_valid && (!ov_q || pop);
	assign job_pop = load && (rest == 3'b000);
	assign empty   = !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			done_q <= '0;
		end else begin
			if (load) begin
				ov_q   <= 1'b1;
				done_q <= job_pop ? 3'b000 : (done_q | pbit);
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			disp_x       <= head.x + 9'(sel);
			disp_y       <= head.y;
			color        <= nfs_pkg::pal_color(code);
			row_twice    <= head.twice;
			last_of_item <= (rest == 3'b000);
		end
	end

`ifndef SYNTH
	a_job_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head.mask != 3'b000))
		else $error("empty job reached the pixel emitter");
	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((done_q & ~head.mask) == 3'b000))
		else $error("emitted pixel not in job mask");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !pop) |=> (ov_q && $stable({disp_x, disp_y, color, row_twice, last_of_item})))
		else $error("waiting pixel changed before it was taken");
`endif

endmodule

### src/nibble_frame_scaler_rgb565_unit.sv
`timescale 1ns / 1ps
// Top level of the nibble frame scaler: 4bpp raster bytes in, RGB565 display pixels out.
// An item that yields pixels is written to the job queue, then loaded into the output register once it is free.
// Throughput: an item is taken every cycle while the job queue has room; the emitter gives
// one pixel per cycle while the output register is free or being popped, 0 to 3 pixels per item.
// Reset: asynchronous; counters clear, scale_mode to none, border_on to 1, queue empty.
module nibble_frame_scaler_rgb565_unit #(
	parameter int DISP_WIDTH        = 320,
	parameter int DISP_HEIGHT       = 240,
	parameter int SRC_ROWS          = 256,
	parameter int SRC_BYTES_PER_ROW = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  pixel_pair,
	input  logic        frame_start,
	output logic        empty,
	input  logic        pop,
	output logic [8:0]  disp_x,
	output logic [7:0]  disp_y,
	output logic [15:0] color,
	output logic        row_twice,
	output logic        last_of_item
);

	logic          take;
	logic          job_push, job_pop, head_valid;
	nfs_pkg::job_t job, head;

	assign take = push && !full;

	nfs_front #(
		.DISP_WIDTH        (DISP_WIDTH),
		.DISP_HEIGHT       (DISP_HEIGHT),
		.SRC_ROWS          (SRC_ROWS),
		.SRC_BYTES_PER_ROW (SRC_BYTES_PER_ROW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.take        (take),
		.pixel_pair  (pixel_pair),
		.frame_start (frame_start),
		.job_push    (job_push),
		.job         (job)
	);

	nfs_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (job_push),
		.wdata      (job),
		.rd         (job_pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	nfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.job_pop      (job_pop),
		.pop          (pop),
		.empty        (empty),
		.disp_x       (disp_x),
		.disp_y       (disp_y),
		.color        (color),
		.row_twice    (row_twice),
		.last_of_item (last_of_item)
	);

endmodule
